/* hw/rtl/ppba_pkg.sv */
// Package with the shared types, codes and helper function of the page bitmap allocator.
`default_nettype none

package ppba_pkg;

  // Width of each configuration register and of the register index.
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_START = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] TOTAL_PAGES_RESET  = 17'd65536;
  localparam logic [CFG_W-1:0] SEARCH_START_RESET = 17'd0;

  // Payload widths of the channels.
  localparam int OP_W   = 2;
  localparam int PAGE_W = 16;

  // Operation codes carried by an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_MARK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_ALLOC = 2'd2
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Port controls of the bitmap memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Position of the lowest clear bit of a bitmap byte (0 when the byte is full).
  function automatic logic [2:0] first_zero(input logic [7:0] v);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) pos = 3'(i);
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ppba_if.sv */
// Channel interfaces of the page bitmap allocator: request and response.
`default_nettype none

interface ppba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] page_index;
  logic        used_flag;

  modport source (output valid, output operation, output page_index, output used_flag,
                  input ready);
  modport sink (input valid, input operation, input page_index, input used_flag,
                output ready);
endinterface

interface ppba_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_page;
  logic        page_used;
  logic        found;

  modport source (output valid, output result_page, output page_used, output found,
                  input ready);
  modport sink (input valid, input result_page, input page_used, input found,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/ppba_mem.sv */
// Byte-wide bitmap memory with one write port and one registered read port.
`default_nettype none

module ppba_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire                  clk,
  input  ppba_pkg::mem_ctl_t   ctl,
  input  wire  [AW-1:0]        waddr,
  input  wire  [7:0]           wdata,
  input  wire  [AW-1:0]        raddr,
  output logic [7:0]           rdata
);
  import ppba_pkg::*;

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ppba_ctrl.sv */
// Controller: clearing pass, mark read-modify-write, query read, first-fit scan, result register.
`default_nettype none

module ppba_ctrl #(
  parameter int MAX_PAGES = 65536
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  [ppba_pkg::CFG_W-1:0]       total_pages,
  input  wire  [ppba_pkg::CFG_W-1:0]       search_start_page,
  ppba_in_if.sink                          req,
  ppba_out_if.source                       rsp,
  output ppba_pkg::mem_ctl_t               mem_ctl,
  output logic [$clog2((MAX_PAGES+7)/8)-1:0] mem_waddr,
  output logic [7:0]                       mem_wdata,
  output logic [$clog2((MAX_PAGES+7)/8)-1:0] mem_raddr,
  input  wire  [7:0]                       mem_rdata
);
  import ppba_pkg::*;

  localparam int DEPTH = (MAX_PAGES + 7) / 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(MAX_PAGES + 1);
  localparam int CW    = (TW > CFG_W) ? TW : CFG_W;
  localparam int IW    = CW - 3;

  state_t              state, state_next;
  logic [AW-1:0]       clr, clr_next;
  logic [IW-1:0]       idx, idx_next;
  logic [AW-1:0]       baddr, baddr_next;
  logic [2:0]          bpos, bpos_next;
  logic                mark_q, mark_next;
  logic                flag_q, flag_next;
  logic [PAGE_W-1:0]   res_page, res_page_next;
  logic                res_used, res_used_next;
  logic                res_found, res_found_next;
  logic                in_ready;
  logic                load_out;
  logic                out_free;

  logic [CW-1:0]       total_ext;
  logic [CW-1:0]       eff_total;
  logic [IW-1:0]       stop_byte;
  logic [IW-1:0]       start_byte;
  logic [CW-1:0]       page_ext;
  logic                page_in_range;
  logic [AW-1:0]       page_addr;
  logic [IW-1:0]       idx_inc;
  logic [2:0]          zero_pos;
  logic [CW-1:0]       found_page;
  logic [7:0]          bit_mask;

  // Bounds derived from the configuration registers.
  assign total_ext     = CW'(total_pages);
  assign eff_total     = (total_ext > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : total_ext;
  assign stop_byte     = eff_total[CW-1:3];
  assign start_byte    = IW'(search_start_page[CFG_W-1:3]);
  assign page_ext      = CW'(req.page_index);
  assign page_in_range = page_ext < eff_total;
  assign page_addr     = page_ext[AW+2:3];

  // Scan helpers on the byte just read.
  assign idx_inc    = idx + IW'(1);
  assign zero_pos   = first_zero(mem_rdata);
  assign found_page = {idx, zero_pos};
  assign bit_mask   = 8'b1 << bpos;

  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = in_ready;

  // Next state, memory controls and next values of the working registers.
  always_comb begin
    state_next     = state;
    clr_next       = clr;
    idx_next       = idx;
    baddr_next     = baddr;
    bpos_next      = bpos;
    mark_next      = mark_q;
    flag_next      = flag_q;
    res_page_next  = res_page;
    res_used_next  = res_used;
    res_found_next = res_found;
    mem_ctl        = '0;
    mem_waddr      = baddr;
    mem_wdata      = mem_rdata;
    mem_raddr      = baddr;
    in_ready       = 1'b0;
    load_out       = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = clr;
        mem_wdata     = 8'h00;
        clr_next      = clr + AW'(1);
        if (clr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (req.valid) begin
          res_used_next  = 1'b0;
          res_found_next = 1'b0;
          case (op_t'(req.operation)) inside
            OP_MARK, OP_QUERY: begin
              res_page_next = req.page_index;
              baddr_next    = page_addr;
              bpos_next     = req.page_index[2:0];
              mark_next     = (op_t'(req.operation) == OP_MARK);
              flag_next     = req.used_flag;
              if (page_in_range) begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = page_addr;
                state_next    = ST_ACCESS;
              end else begin
                state_next = ST_EMIT;
              end
            end
            OP_ALLOC: begin
              res_page_next = '0;
              if (start_byte < stop_byte) begin
                idx_next      = start_byte;
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = start_byte[AW-1:0];
                state_next    = ST_SCAN;
              end else begin
                state_next = ST_EMIT;
              end
            end
            default: begin
              res_page_next = '0;
              state_next    = ST_EMIT;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        // The byte of the page is in the read register now.
        if (mark_q) begin
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = baddr;
          mem_wdata     = flag_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
        end else begin
          res_used_next = mem_rdata[bpos];
        end
        state_next = ST_EMIT;
      end

      ST_SCAN: begin
        // One bitmap byte per cycle; the next read is issued while this one is checked.
        if (mem_rdata != 8'hFF) begin
          mem_ctl.wr_en  = 1'b1;
          mem_waddr      = idx[AW-1:0];
          mem_wdata      = mem_rdata | (8'b1 << zero_pos);
          res_page_next  = found_page[PAGE_W-1:0];
          res_found_next = 1'b1;
          state_next     = ST_EMIT;
        end else if (idx_inc >= stop_byte) begin
          state_next = ST_EMIT;
        end else begin
          idx_next      = idx_inc;
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = idx_inc[AW-1:0];
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  // Working registers of the transaction in progress.
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    baddr     <= baddr_next;
    bpos      <= bpos_next;
    mark_q    <= mark_next;
    flag_q    <= flag_next;
    res_page  <= res_page_next;
    res_used  <= res_used_next;
    res_found <= res_found_next;
  end

  // Result register towards the response channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.result_page <= res_page;
      rsp.page_used   <= res_used;
      rsp.found       <= res_found;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/physical_page_bitmap_allocator.sv */
// Sequence: an in-range mark or query passes through ST_ACCESS and then ST_EMIT before its
// response is registered; other marks and queries and code three go straight to ST_EMIT;
// allocate scans in ST_SCAN (up to MAX_PAGES/8 bytes) before ST_EMIT. Throughput: one transaction at
// a time; the next request is taken in ST_IDLE after the response is loaded, and loading waits
// while the previous response is still held. Reset: synchronous; a clearing pass then writes
// all (MAX_PAGES+7)/8 bytes (8192 by default), one per cycle; configuration is taken always.
`default_nettype none

module physical_page_bitmap_allocator #(
  parameter int MAX_PAGES = 65536
) (
  input  wire                               clk,
  input  wire                               rst,
  ppba_in_if.sink                           req,
  ppba_out_if.source                        rsp,
  input  wire                               cfg_we,
  input  wire  [ppba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [ppba_pkg::CFG_W-1:0]        cfg_wdata
);
  import ppba_pkg::*;

  localparam int DEPTH = (MAX_PAGES + 7) / 8;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_W-1:0] total_pages;
  logic [CFG_W-1:0] search_start_page;
  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages       <= TOTAL_PAGES_RESET;
      search_start_page <= SEARCH_START_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_PAGES:  total_pages       <= cfg_wdata;
        REG_SEARCH_START: search_start_page <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer for clearing, read-modify-write and scan.
  ppba_ctrl #(
    .MAX_PAGES (MAX_PAGES)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .total_pages       (total_pages),
    .search_start_page (search_start_page),
    .req               (req),
    .rsp               (rsp),
    .mem_ctl           (mem_ctl),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

  // Used-page bitmap, one byte per eight pages.
  ppba_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Only one transaction is in flight: taking one drops ready in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while a transaction is in flight");

  // A write-back never coincides with a read, so no same-entry overlap can occur.
  assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> !mem_ctl.rd_en)
    else $error("bitmap read and write in the same cycle");

  // A successful allocation never reports a query bit.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> !rsp.page_used)
    else $error("allocation result carries a query bit");

endmodule

`default_nettype wire

/* bench/ppba_checker.sv */
// Scoreboard of the page bitmap allocator: keeps a shadow bitmap, predicts and checks responses.
module ppba_checker
  import ppba_pkg::*;
#(
  parameter int MAX_PAGES = 65536
) (
  input  wire                 clk,
  input  wire                 rst,
  ppba_in_if                  req,
  ppba_out_if                 rsp,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [CFG_W-1:0]     cfg_wdata,
  output int                  err_count,
  output int                  pending,
  output int                  granted
);

  localparam int BITMAP_BYTES = (MAX_PAGES + 7) / 8;
  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              used;
    logic              found;
  } page_result_t;

  logic [7:0]       shadow_bitmap [BITMAP_BYTES];
  logic [CFG_W-1:0] total_pages_reg;
  logic [CFG_W-1:0] search_start_reg;
  page_result_t     expected_results [$];
  int               responses_seen;

  // Prints one line per mismatch (up to a limit) and counts every one of them.
  task automatic report_mismatch(input string msg);
    if (err_count < REPORT_LIMIT) begin
      $display("ppba_checker: %s", msg);
    end
    err_count++;
  endtask

  // Applies one request to the shadow bitmap and works out the response it should give.
  task automatic predict_page_result(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                                     input logic mark_used, output page_result_t res);
    int present;
    int byte_idx;
    int last_byte;
    int slot;
    logic [7:0] bits;
    // Totals above the bitmap size act as the bitmap size.
    present = (int'(total_pages_reg) > MAX_PAGES) ? MAX_PAGES : int'(total_pages_reg);
    res = '0;
    case (op)
      OP_MARK: begin
        res.page = page;
        if (int'(page) < present) begin
          shadow_bitmap[page >> 3][page[2:0]] = mark_used;
        end
      end
      OP_QUERY: begin
        res.page = page;
        if (int'(page) < present) begin
          res.used = shadow_bitmap[page >> 3][page[2:0]];
        end
      end
      OP_ALLOC: begin
        // Whole bytes only: a partial last byte is never searched.
        last_byte = present >> 3;
        for (byte_idx = int'(search_start_reg) >> 3; byte_idx < last_byte && !res.found;
             byte_idx++) begin
          bits = shadow_bitmap[byte_idx];
          for (slot = 0; slot < 8 && !res.found; slot++) begin
            if (!bits[slot] && (byte_idx * 8 + slot) < present) begin
              shadow_bitmap[byte_idx][slot] = 1'b1;
              res.page  = PAGE_W'(byte_idx * 8 + slot);
              res.found = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    page_result_t observed;
    page_result_t wanted;
    if (rst) begin
      foreach (shadow_bitmap[i]) shadow_bitmap[i] = '0;
      total_pages_reg  = TOTAL_PAGES_RESET;
      search_start_reg = SEARCH_START_RESET;
      expected_results.delete();
      err_count      = 0;
      granted        = 0;
      responses_seen = 0;
    end else begin
      // A response transaction is compared with the oldest outstanding prediction.
      if (rsp.valid && rsp.ready) begin
        observed.page  = rsp.result_page;
        observed.used  = rsp.page_used;
        observed.found = rsp.found;
        responses_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                    responses_seen));
        end else begin
          wanted = expected_results.pop_front();
          if (observed.page !== wanted.page) begin
            report_mismatch($sformatf("response %0d: result_page %0d, expected %0d",
                                      responses_seen, observed.page, wanted.page));
          end
          if (observed.used !== wanted.used) begin
            report_mismatch($sformatf("response %0d: page_used %b, expected %b",
                                      responses_seen, observed.used, wanted.used));
          end
          if (observed.found !== wanted.found) begin
            report_mismatch($sformatf("response %0d: found %b, expected %b",
                                      responses_seen, observed.found, wanted.found));
          end
        end
      end
      // A request transaction updates the shadow state and queues its response.
      if (req.valid && req.ready) begin
        predict_page_result(req.operation, req.page_index, req.used_flag, wanted);
        if (wanted.found) begin
          granted++;
        end
        expected_results.push_back(wanted);
      end
      // Register writes; any other index is ignored.
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL_PAGES) begin
          total_pages_reg = cfg_wdata;
        end else if (cfg_index == REG_SEARCH_START) begin
          search_start_reg = cfg_wdata;
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* bench/tb_top.sv */
// Testbench top of the page bitmap allocator: clock, reset, stimulus and the verdict.
module tb_top;
  import ppba_pkg::*;

  localparam int MAX_PAGES    = 65536;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 16;

  // Codes the block must tolerate but that the package leaves unnamed.
  localparam logic [OP_W-1:0]      OP_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int err_count;
  int pending;
  int granted;
  int sent_per_op [4];
  int settings_used;
  bit spare_toggle;
  bit req_idle_on;
  bit rsp_idle_on;
  int rsp_stall_left;

  ppba_in_if  req_ch ();
  ppba_out_if rsp_ch ();

  physical_page_bitmap_allocator #(.MAX_PAGES(MAX_PAGES)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ppba_checker #(.MAX_PAGES(MAX_PAGES)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .err_count (err_count),
    .pending   (pending),
    .granted   (granted)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Safety net against a hung handshake.
  initial begin
    #100_000_000;
    $display("Run timed out with %0d responses outstanding", pending);
    $display("tb_top: errors");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Response side: ready drops for random stretches while idling is switched on.
  always @(negedge clk) begin
    if (rst || !rsp_idle_on) begin
      rsp_stall_left = 0;
      rsp_ch.ready <= 1'b1;
    end else if (rsp_stall_left > 0) begin
      rsp_stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_stall_left = gap_len();
      rsp_ch.ready <= (rsp_stall_left == 0);
    end
  end

  // Presents one request and returns at the falling edge after its transaction.
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                               input logic used);
    int gap;
    gap = req_idle_on ? gap_len() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.page_index <= page;
    req_ch.used_flag  <= used;
    do @(posedge clk); while (!req_ch.ready);
    sent_per_op[op]++;
    @(negedge clk);
  endtask

  // Waits until every response is back and the block has had time to settle.
  task automatic drain_outstanding();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes both registers, then a write to an unused index that must change nothing.
  task automatic apply_settings(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] start);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TOTAL_PAGES;
    cfg_wdata <= total;
    @(negedge clk);
    cfg_index <= REG_SEARCH_START;
    cfg_wdata <= start;
    @(negedge clk);
    cfg_index <= spare_toggle ? REG_SPARE_HI : REG_SPARE_LO;
    cfg_wdata <= CFG_W'($urandom);
    spare_toggle = !spare_toggle;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One random request, with pages drawn mostly around the live allocation window.
  task automatic random_item(input int total, input int start);
    int pick;
    int lo;
    int hi;
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_ALLOC;
    else if (pick < 75) op = OP_MARK;
    else if (pick < 97) op = OP_QUERY;
    else op = OP_SPARE;
    hi = (total + 8 > MAX_PAGES - 1) ? MAX_PAGES - 1 : total + 8;
    lo = start & ~7;
    if (lo > hi) lo = (hi > 64) ? hi - 64 : 0;
    if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom);
    else page = PAGE_W'($urandom_range(hi, lo));
    // Freeing slightly more often than setting keeps allocation busy.
    issue_request(op, page, $urandom_range(0, 9) < 4);
  endtask

  initial begin : stimulus
    int kind;
    int total;
    int start;
    int phase_len;
    int random_sent;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_TOTAL_PAGES;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_MARK;
    req_ch.page_index = '0;
    req_ch.used_flag  = 1'b0;
    rsp_ch.ready      = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: fresh bitmap, both ends of the page range, first fit and freeing.
    issue_request(OP_QUERY, 16'd0, 1'b0);
    issue_request(OP_QUERY, 16'hFFFF, 1'b0);
    issue_request(OP_MARK, 16'd0, 1'b1);
    issue_request(OP_MARK, 16'hFFFF, 1'b1);
    issue_request(OP_QUERY, 16'hFFFF, 1'b0);
    issue_request(OP_ALLOC, 16'h5555, 1'b1);
    issue_request(OP_MARK, 16'd1, 1'b0);
    issue_request(OP_ALLOC, 16'd0, 1'b0);
    issue_request(OP_MARK, 16'd0, 1'b0);
    issue_request(OP_ALLOC, 16'hAAAA, 1'b0);
    issue_request(OP_SPARE, 16'hFFFF, 1'b1);
    issue_request(OP_QUERY, 16'hAAAA, 1'b1);

    // No pages at all: everything lies out of bounds and allocation fails.
    drain_outstanding();
    apply_settings(17'd0, 17'd0);
    issue_request(OP_MARK, 16'd5, 1'b1);
    issue_request(OP_QUERY, 16'd5, 1'b0);
    issue_request(OP_ALLOC, 16'd0, 1'b0);

    // Oversized total saturates; only the top byte is searched, until it runs full.
    drain_outstanding();
    apply_settings(17'h1FFFF, 17'd65528);
    repeat (8) issue_request(OP_ALLOC, 16'd0, 1'b0);
    issue_request(OP_QUERY, 16'hFFFF, 1'b0);

    // Partial last byte and an unaligned search start.
    drain_outstanding();
    apply_settings(17'd100, 17'd17);
    issue_request(OP_ALLOC, 16'd0, 1'b0);
    issue_request(OP_MARK, 16'd99, 1'b1);
    issue_request(OP_MARK, 16'd100, 1'b1);
    issue_request(OP_QUERY, 16'd100, 1'b0);

    // Search start beyond the end.
    drain_outstanding();
    apply_settings(17'd65536, 17'd65536);
    issue_request(OP_ALLOC, 16'd0, 1'b0);

    // Random phases, each under fresh settings and idling modes.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_outstanding();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        total = $urandom_range(0, 1) ? MAX_PAGES : 17'h1FFFF;
        start = $urandom_range(0, MAX_PAGES);
      end else if (kind == 1) begin
        total = $urandom_range(0, 16);
        start = $urandom_range(0, 16);
      end else begin
        total = $urandom_range(8, 600);
        start = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total + 16)
                                            : $urandom_range(0, total / 2);
      end
      req_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
      apply_settings(CFG_W'(total), CFG_W'(start));
      phase_len = $urandom_range(30, 150);
      repeat (phase_len) begin
        random_item(total, start);
        random_sent++;
      end
    end

    drain_outstanding();
    $display("Covered %0d marks, %0d queries, %0d allocations (%0d granted), %0d spare codes",
             sent_per_op[OP_MARK], sent_per_op[OP_QUERY], sent_per_op[OP_ALLOC], granted,
             sent_per_op[OP_SPARE]);
    $display("across %0d register settings, with idling and stalls on both channels",
             settings_used);
    if (err_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
